@@ hdl/alpf_pkg.sv @@
package alpf_pkg;

  // Width of the internal state and of the multiplier and adder results.
  localparam int unsigned ACC_WIDTH = 32;

  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,
    MODE_DF2   = 2'd1,
    MODE_TDF2  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_K    = 2'd1,
    REG_C0   = 2'd2,
    REG_C1   = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    MA_FWD0,
    MA_FWD1,
    MA_W
  } mul_a_e;

  typedef enum logic [1:0] {
    MC_K,
    MC_C0,
    MC_C1
  } mul_c_e;

  typedef enum logic [2:0] {
    AA_ZERO,
    AA_X,
    AA_ACC,
    AA_FWD0,
    AA_FWD1,
    AA_OUT0,
    AA_OUT1,
    AA_PROD
  } alu_a_e;

  typedef enum logic [2:0] {
    AB_ZERO,
    AB_X,
    AB_PROD,
    AB_PSAVE,
    AB_FWD0,
    AB_FWD1
  } alu_b_e;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_ACC,
    DST_W,
    DST_FWD0,
    DST_FWD1,
    DST_OUT0,
    DST_Y
  } dst_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FO_MUL1,
    ST_FO_WAIT1,
    ST_FO_W,
    ST_FO_MUL2,
    ST_FO_WAIT2,
    ST_FO_Y,
    ST_DF_MUL1,
    ST_DF_MUL0,
    ST_DF_T1,
    ST_DF_T0,
    ST_DF_W,
    ST_DF_MULW,
    ST_DF_WAIT,
    ST_DF_Y0,
    ST_DF_Y1,
    ST_TR_W,
    ST_TR_MUL0,
    ST_TR_MUL1,
    ST_TR_FWD0,
    ST_TR_FWD1,
    ST_TR_Y,
    ST_TR_OUT0,
    ST_ZERO,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic   mul_go;
    mul_a_e mul_a;
    mul_c_e mul_c;
    alu_a_e alu_a;
    alu_b_e alu_b;
    logic   alu_sub;
    dst_e   dst;
    logic   save_prod;
    logic   shift_fwd;
    logic   w_to_fwd0;
    logic   w_to_out1;
    logic   load_out;
  } ctrl_t;

endpackage

@@ hdl/alpf_fmul.sv @@
module alpf_fmul #(
  parameter int unsigned COEF_WIDTH = 32
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          go_i,
  input  logic signed [alpf_pkg::ACC_WIDTH-1:0]         a_i,
  input  logic signed [COEF_WIDTH-1:0]                  coef_i,
  output logic signed [alpf_pkg::ACC_WIDTH-1:0]         res_o
);

  localparam int unsigned ACC_W = alpf_pkg::ACC_WIDTH;
  localparam int unsigned PW    = ACC_W + COEF_WIDTH;
  localparam int unsigned FRAC  = COEF_WIDTH - 2;
  localparam int unsigned SHW   = PW - FRAC;
  localparam logic [PW-1:0] RND = PW'(1) << (FRAC - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = {1'b1, {(ACC_W - 1){1'b0}}};

  logic signed [PW-1:0]    prod_d;
  logic signed [PW-1:0]    prod_q;
  logic                    prod_vld_q;
  logic signed [ACC_W-1:0] res_d;
  logic signed [ACC_W-1:0] res_q;

  assign prod_d = a_i * coef_i;

  // Round half up, floor shift by the coefficient fraction bits, then clamp.
  always_comb begin
    logic [PW-1:0]    rnd;
    logic [SHW-1:0]   sh;
    logic [SHW-ACC_W:0] hi;
    rnd = prod_q + RND;
    sh  = rnd[PW-1:FRAC];
    hi  = sh[SHW-1:ACC_W-1];
    if ((&hi) || !(|hi)) begin
      res_d = $signed(sh[ACC_W-1:0]);
    end else if (sh[SHW-1]) begin
      res_d = SAT_MIN;
    end else begin
      res_d = SAT_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= go_i;
    end
  end

  // The result holds until the next product arrives.
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      prod_q <= prod_d;
    end
    if (prod_vld_q) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ hdl/alpf_alu.sv @@
module alpf_alu (
  input  logic signed [alpf_pkg::ACC_WIDTH-1:0] a_i,
  input  logic signed [alpf_pkg::ACC_WIDTH-1:0] b_i,
  input  logic                                  sub_i,
  output logic signed [alpf_pkg::ACC_WIDTH-1:0] res_o
);

  localparam int unsigned ACC_W = alpf_pkg::ACC_WIDTH;
  localparam logic signed [ACC_W-1:0] SAT_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = {1'b1, {(ACC_W - 1){1'b0}}};

  logic signed [ACC_W:0] a_ext;
  logic signed [ACC_W:0] b_ext;
  logic signed [ACC_W:0] sum;

  assign a_ext = (ACC_W + 1)'(a_i);
  assign b_ext = (ACC_W + 1)'(b_i);
  assign sum   = sub_i ? (a_ext - b_ext) : (a_ext + b_ext);

  always_comb begin
    if (sum[ACC_W] == sum[ACC_W-1]) begin
      res_o = sum[ACC_W-1:0];
    end else if (sum[ACC_W]) begin
      res_o = SAT_MIN;
    end else begin
      res_o = SAT_MAX;
    end
  end

endmodule

@@ hdl/alpf_ctrl.sv @@
module alpf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  alpf_pkg::mode_e       mode_i,
  input  logic                  out_free_i,
  output logic                  idle_o,
  output alpf_pkg::ctrl_t       ctrl_o
);

  alpf_pkg::state_e state_q;
  alpf_pkg::state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= alpf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      alpf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (mode_i)
            alpf_pkg::MODE_FIRST: state_d = alpf_pkg::ST_FO_MUL1;
            alpf_pkg::MODE_DF2:   state_d = alpf_pkg::ST_DF_MUL1;
            alpf_pkg::MODE_TDF2:  state_d = alpf_pkg::ST_TR_W;
            default:              state_d = alpf_pkg::ST_ZERO;
          endcase
        end
      end
      alpf_pkg::ST_FO_MUL1:  state_d = alpf_pkg::ST_FO_WAIT1;
      alpf_pkg::ST_FO_WAIT1: state_d = alpf_pkg::ST_FO_W;
      alpf_pkg::ST_FO_W:     state_d = alpf_pkg::ST_FO_MUL2;
      alpf_pkg::ST_FO_MUL2:  state_d = alpf_pkg::ST_FO_WAIT2;
      alpf_pkg::ST_FO_WAIT2: state_d = alpf_pkg::ST_FO_Y;
      alpf_pkg::ST_FO_Y:     state_d = alpf_pkg::ST_OUT;
      alpf_pkg::ST_DF_MUL1:  state_d = alpf_pkg::ST_DF_MUL0;
      alpf_pkg::ST_DF_MUL0:  state_d = alpf_pkg::ST_DF_T1;
      alpf_pkg::ST_DF_T1:    state_d = alpf_pkg::ST_DF_T0;
      alpf_pkg::ST_DF_T0:    state_d = alpf_pkg::ST_DF_W;
      alpf_pkg::ST_DF_W:     state_d = alpf_pkg::ST_DF_MULW;
      alpf_pkg::ST_DF_MULW:  state_d = alpf_pkg::ST_DF_WAIT;
      alpf_pkg::ST_DF_WAIT:  state_d = alpf_pkg::ST_DF_Y0;
      alpf_pkg::ST_DF_Y0:    state_d = alpf_pkg::ST_DF_Y1;
      alpf_pkg::ST_DF_Y1:    state_d = alpf_pkg::ST_OUT;
      alpf_pkg::ST_TR_W:     state_d = alpf_pkg::ST_TR_MUL0;
      alpf_pkg::ST_TR_MUL0:  state_d = alpf_pkg::ST_TR_MUL1;
      alpf_pkg::ST_TR_MUL1:  state_d = alpf_pkg::ST_TR_FWD0;
      alpf_pkg::ST_TR_FWD0:  state_d = alpf_pkg::ST_TR_FWD1;
      alpf_pkg::ST_TR_FWD1:  state_d = alpf_pkg::ST_TR_Y;
      alpf_pkg::ST_TR_Y:     state_d = alpf_pkg::ST_TR_OUT0;
      alpf_pkg::ST_TR_OUT0:  state_d = alpf_pkg::ST_OUT;
      alpf_pkg::ST_ZERO:     state_d = alpf_pkg::ST_OUT;
      alpf_pkg::ST_OUT: begin
        if (out_free_i) begin
          state_d = alpf_pkg::ST_IDLE;
        end
      end
      default: state_d = alpf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.mul_go    = 1'b0;
    ctrl_o.mul_a     = alpf_pkg::MA_FWD0;
    ctrl_o.mul_c     = alpf_pkg::MC_K;
    ctrl_o.alu_a     = alpf_pkg::AA_ZERO;
    ctrl_o.alu_b     = alpf_pkg::AB_ZERO;
    ctrl_o.alu_sub   = 1'b0;
    ctrl_o.dst       = alpf_pkg::DST_NONE;
    ctrl_o.save_prod = 1'b0;
    ctrl_o.shift_fwd = 1'b0;
    ctrl_o.w_to_fwd0 = 1'b0;
    ctrl_o.w_to_out1 = 1'b0;
    ctrl_o.load_out  = 1'b0;
    unique case (state_q)
      alpf_pkg::ST_FO_MUL1: begin
        ctrl_o.mul_go = 1'b1;
        ctrl_o.mul_a  = alpf_pkg::MA_FWD0;
        ctrl_o.mul_c  = alpf_pkg::MC_K;
      end
      alpf_pkg::ST_FO_W: begin
        ctrl_o.alu_a   = alpf_pkg::AA_X;
        ctrl_o.alu_b   = alpf_pkg::AB_PROD;
        ctrl_o.alu_sub = 1'b1;
        ctrl_o.dst     = alpf_pkg::DST_W;
      end
      alpf_pkg::ST_FO_MUL2: begin
        ctrl_o.mul_go = 1'b1;
        ctrl_o.mul_a  = alpf_pkg::MA_W;
        ctrl_o.mul_c  = alpf_pkg::MC_K;
      end
      alpf_pkg::ST_FO_Y: begin
        ctrl_o.alu_a     = alpf_pkg::AA_FWD0;
        ctrl_o.alu_b     = alpf_pkg::AB_PROD;
        ctrl_o.dst       = alpf_pkg::DST_Y;
        ctrl_o.w_to_fwd0 = 1'b1;
      end
      alpf_pkg::ST_DF_MUL1: begin
        ctrl_o.mul_go = 1'b1;
        ctrl_o.mul_a  = alpf_pkg::MA_FWD1;
        ctrl_o.mul_c  = alpf_pkg::MC_C1;
      end
      alpf_pkg::ST_DF_MUL0: begin
        ctrl_o.mul_go = 1'b1;
        ctrl_o.mul_a  = alpf_pkg::MA_FWD0;
        ctrl_o.mul_c  = alpf_pkg::MC_C0;
      end
      alpf_pkg::ST_DF_T1: begin
        ctrl_o.alu_a   = alpf_pkg::AA_ZERO;
        ctrl_o.alu_b   = alpf_pkg::AB_PROD;
        ctrl_o.alu_sub = 1'b1;
        ctrl_o.dst     = alpf_pkg::DST_ACC;
      end
      alpf_pkg::ST_DF_T0: begin
        // The c0 product is needed again for the output sum.
        ctrl_o.alu_a     = alpf_pkg::AA_ACC;
        ctrl_o.alu_b     = alpf_pkg::AB_PROD;
        ctrl_o.alu_sub   = 1'b1;
        ctrl_o.dst       = alpf_pkg::DST_ACC;
        ctrl_o.save_prod = 1'b1;
      end
      alpf_pkg::ST_DF_W: begin
        ctrl_o.alu_a = alpf_pkg::AA_ACC;
        ctrl_o.alu_b = alpf_pkg::AB_X;
        ctrl_o.dst   = alpf_pkg::DST_W;
      end
      alpf_pkg::ST_DF_MULW: begin
        ctrl_o.mul_go = 1'b1;
        ctrl_o.mul_a  = alpf_pkg::MA_W;
        ctrl_o.mul_c  = alpf_pkg::MC_C1;
      end
      alpf_pkg::ST_DF_Y0: begin
        ctrl_o.alu_a = alpf_pkg::AA_PROD;
        ctrl_o.alu_b = alpf_pkg::AB_PSAVE;
        ctrl_o.dst   = alpf_pkg::DST_ACC;
      end
      alpf_pkg::ST_DF_Y1: begin
        ctrl_o.alu_a     = alpf_pkg::AA_ACC;
        ctrl_o.alu_b     = alpf_pkg::AB_FWD1;
        ctrl_o.dst       = alpf_pkg::DST_Y;
        ctrl_o.shift_fwd = 1'b1;
      end
      alpf_pkg::ST_TR_W: begin
        ctrl_o.alu_a = alpf_pkg::AA_X;
        ctrl_o.alu_b = alpf_pkg::AB_FWD0;
        ctrl_o.dst   = alpf_pkg::DST_W;
      end
      alpf_pkg::ST_TR_MUL0: begin
        ctrl_o.mul_go = 1'b1;
        ctrl_o.mul_a  = alpf_pkg::MA_W;
        ctrl_o.mul_c  = alpf_pkg::MC_C0;
      end
      alpf_pkg::ST_TR_MUL1: begin
        ctrl_o.mul_go = 1'b1;
        ctrl_o.mul_a  = alpf_pkg::MA_W;
        ctrl_o.mul_c  = alpf_pkg::MC_C1;
      end
      alpf_pkg::ST_TR_FWD0: begin
        ctrl_o.alu_a     = alpf_pkg::AA_FWD1;
        ctrl_o.alu_b     = alpf_pkg::AB_PROD;
        ctrl_o.alu_sub   = 1'b1;
        ctrl_o.dst       = alpf_pkg::DST_FWD0;
        ctrl_o.save_prod = 1'b1;
      end
      alpf_pkg::ST_TR_FWD1: begin
        ctrl_o.alu_a   = alpf_pkg::AA_ZERO;
        ctrl_o.alu_b   = alpf_pkg::AB_PROD;
        ctrl_o.alu_sub = 1'b1;
        ctrl_o.dst     = alpf_pkg::DST_FWD1;
      end
      alpf_pkg::ST_TR_Y: begin
        // The multiplier still holds the c1 product here.
        ctrl_o.alu_a = alpf_pkg::AA_OUT0;
        ctrl_o.alu_b = alpf_pkg::AB_PROD;
        ctrl_o.dst   = alpf_pkg::DST_Y;
      end
      alpf_pkg::ST_TR_OUT0: begin
        ctrl_o.alu_a     = alpf_pkg::AA_OUT1;
        ctrl_o.alu_b     = alpf_pkg::AB_PSAVE;
        ctrl_o.dst       = alpf_pkg::DST_OUT0;
        ctrl_o.w_to_out1 = 1'b1;
      end
      alpf_pkg::ST_ZERO: begin
        ctrl_o.dst = alpf_pkg::DST_Y;
      end
      alpf_pkg::ST_OUT: begin
        ctrl_o.load_out = out_free_i;
      end
      default: begin
      end
    endcase
  end

  assign idle_o = (state_q == alpf_pkg::ST_IDLE);

endmodule

@@ hdl/allpass_filter_section_unit.sv @@
// Channel  | Valid        | Stall        | Payload
// ---------+--------------+--------------+-----------------------------------
// input    | in_valid_i   | in_stall_o   | sample_in_i  (Q1.23)
// output   | out_valid_o  | out_stall_i  | sample_out_o (Q1.23, saturated)
// config   | cfg_we_i     | none         | cfg_index_i, cfg_data_i
//
// An item is worked through a run of controller states that depends on the
// mode, and the block takes no new item before it is back in ST_IDLE. The
// pace is set by the one shared multiplier, whose result is registered, and by
// the single saturating adder that every sum goes through.
// Reset clears the filter state and the registers; nothing else needs a pass.
// A stalled output holds its result while the next item is already accepted.
module allpass_filter_section_unit #(
  parameter int unsigned SAMPLE_WIDTH = 24,
  parameter int unsigned COEF_WIDTH   = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_index_i,
  input  logic [COEF_WIDTH-1:0]          cfg_data_i
);

  localparam int unsigned ACC_W = alpf_pkg::ACC_WIDTH;
  localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX =
    {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN =
    {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

  alpf_pkg::mode_e               mode_q;
  logic signed [COEF_WIDTH-1:0]  k_q;
  logic signed [COEF_WIDTH-1:0]  c0_q;
  logic signed [COEF_WIDTH-1:0]  c1_q;

  logic signed [ACC_W-1:0] x_q;
  logic signed [ACC_W-1:0] w_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] psave_q;
  logic signed [ACC_W-1:0] y_q;
  logic signed [ACC_W-1:0] fwd0_q;
  logic signed [ACC_W-1:0] fwd1_q;
  logic signed [ACC_W-1:0] out0_q;
  logic signed [ACC_W-1:0] out1_q;

  logic                         out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_data_q;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;

  alpf_pkg::ctrl_t              ctrl;
  logic                         idle;
  logic                         out_free;
  logic                         in_accept;

  logic signed [ACC_W-1:0]      mul_a;
  logic signed [COEF_WIDTH-1:0] mul_c;
  logic signed [ACC_W-1:0]      prod;
  logic signed [ACC_W-1:0]      alu_a;
  logic signed [ACC_W-1:0]      alu_b;
  logic signed [ACC_W-1:0]      alu_res;

  assign in_accept = in_valid_i && idle;
  assign out_free  = !out_valid_q || !out_stall_i;

  alpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_q),
    .out_free_i (out_free),
    .idle_o     (idle),
    .ctrl_o     (ctrl)
  );

  always_comb begin
    unique case (ctrl.mul_a)
      alpf_pkg::MA_FWD0: mul_a = fwd0_q;
      alpf_pkg::MA_FWD1: mul_a = fwd1_q;
      alpf_pkg::MA_W:    mul_a = w_q;
      default:           mul_a = w_q;
    endcase
    unique case (ctrl.mul_c)
      alpf_pkg::MC_K:  mul_c = k_q;
      alpf_pkg::MC_C0: mul_c = c0_q;
      alpf_pkg::MC_C1: mul_c = c1_q;
      default:         mul_c = k_q;
    endcase
  end

  alpf_fmul #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_fmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (ctrl.mul_go),
    .a_i    (mul_a),
    .coef_i (mul_c),
    .res_o  (prod)
  );

  always_comb begin
    unique case (ctrl.alu_a)
      alpf_pkg::AA_ZERO: alu_a = '0;
      alpf_pkg::AA_X:    alu_a = x_q;
      alpf_pkg::AA_ACC:  alu_a = acc_q;
      alpf_pkg::AA_FWD0: alu_a = fwd0_q;
      alpf_pkg::AA_FWD1: alu_a = fwd1_q;
      alpf_pkg::AA_OUT0: alu_a = out0_q;
      alpf_pkg::AA_OUT1: alu_a = out1_q;
      alpf_pkg::AA_PROD: alu_a = prod;
      default:           alu_a = '0;
    endcase
    unique case (ctrl.alu_b)
      alpf_pkg::AB_ZERO:  alu_b = '0;
      alpf_pkg::AB_X:     alu_b = x_q;
      alpf_pkg::AB_PROD:  alu_b = prod;
      alpf_pkg::AB_PSAVE: alu_b = psave_q;
      alpf_pkg::AB_FWD0:  alu_b = fwd0_q;
      alpf_pkg::AB_FWD1:  alu_b = fwd1_q;
      default:            alu_b = '0;
    endcase
  end

  alpf_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (ctrl.alu_sub),
    .res_o (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= alpf_pkg::MODE_FIRST;
      k_q    <= '0;
      c0_q   <= '0;
      c1_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (alpf_pkg::reg_e'(cfg_index_i))
        alpf_pkg::REG_MODE: mode_q <= alpf_pkg::mode_e'(cfg_data_i[1:0]);
        alpf_pkg::REG_K:    k_q    <= cfg_data_i;
        alpf_pkg::REG_C0:   c0_q   <= cfg_data_i;
        alpf_pkg::REG_C1:   c1_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Filter state: two recursive-path and two feed-forward-path registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd0_q <= '0;
      fwd1_q <= '0;
      out0_q <= '0;
      out1_q <= '0;
    end else begin
      if (ctrl.dst == alpf_pkg::DST_FWD0) begin
        fwd0_q <= alu_res;
      end else if (ctrl.shift_fwd || ctrl.w_to_fwd0) begin
        fwd0_q <= w_q;
      end
      if (ctrl.dst == alpf_pkg::DST_FWD1) begin
        fwd1_q <= alu_res;
      end else if (ctrl.shift_fwd) begin
        fwd1_q <= fwd0_q;
      end
      if (ctrl.dst == alpf_pkg::DST_OUT0) begin
        out0_q <= alu_res;
      end
      if (ctrl.w_to_out1) begin
        out1_q <= w_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q <= ACC_W'(sample_in_i);
    end
    if (ctrl.dst == alpf_pkg::DST_W) begin
      w_q <= alu_res;
    end
    if (ctrl.dst == alpf_pkg::DST_ACC) begin
      acc_q <= alu_res;
    end
    if (ctrl.dst == alpf_pkg::DST_Y) begin
      y_q <= alu_res;
    end
    if (ctrl.save_prod) begin
      psave_q <= prod;
    end
    if (ctrl.load_out) begin
      out_data_q <= y_sat;
    end
  end

  always_comb begin
    logic [ACC_W-SAMPLE_WIDTH:0] hi;
    hi = y_q[ACC_W-1:SAMPLE_WIDTH-1];
    if ((&hi) || !(|hi)) begin
      y_sat = y_q[SAMPLE_WIDTH-1:0];
    end else if (y_q[ACC_W-1]) begin
      y_sat = OUT_MIN;
    end else begin
      y_sat = OUT_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_stall_o   = !idle;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a waiting result");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block ready right after taking an item");

  a_state_write_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.shift_fwd || ctrl.w_to_fwd0) |->
      (ctrl.dst != alpf_pkg::DST_FWD0 && ctrl.dst != alpf_pkg::DST_FWD1))
    else $error("delay line shift collides with an adder write");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load_out |=> out_valid_o)
    else $error("loaded result not presented");

endmodule

@@ sim/tb_top.sv @@
module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SEGMENTS = 12;
  localparam int SEGMENT_ITEMS = 75;
  localparam int REPORT_MAX = 20;

  // Fixed-point all-pass predictor; holds its own copy of registers and state
  // and the queue of samples still owed by the block.
  class allpass_scoreboard;
    bit [1:0] cur_mode;
    longint k_coef;
    longint c0_coef;
    longint c1_coef;
    longint rec_q[2];
    longint ff_q[2];
    logic signed [23:0] pending_out[$];
    int errors;

    function void write_reg(alpf_pkg::reg_e idx, logic [31:0] data);
      case (idx)
        alpf_pkg::REG_MODE: cur_mode = data[1:0];
        alpf_pkg::REG_K:    k_coef = longint'($signed(data));
        alpf_pkg::REG_C0:   c0_coef = longint'($signed(data));
        alpf_pkg::REG_C1:   c1_coef = longint'($signed(data));
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    // Q2.30 product, rounded half up, saturated to the state width.
    function longint coef_mul(longint a, longint coef);
      return clamp((a * coef + (longint'(1) <<< 29)) >>> 30, 32);
    endfunction

    function void take_sample(logic signed [23:0] xin);
      longint x;
      longint y;
      longint w;
      longint t;
      x = longint'(xin);
      y = 0;
      case (cur_mode)
        alpf_pkg::MODE_FIRST: begin
          w = clamp(x - coef_mul(rec_q[0], k_coef), 32);
          y = clamp(rec_q[0] + coef_mul(w, k_coef), 32);
          rec_q[0] = w;
        end
        alpf_pkg::MODE_DF2: begin
          t = clamp(0 - coef_mul(rec_q[1], c1_coef), 32);
          t = clamp(t - coef_mul(rec_q[0], c0_coef), 32);
          w = clamp(t + x, 32);
          y = coef_mul(w, c1_coef);
          y = clamp(y + coef_mul(rec_q[0], c0_coef), 32);
          y = clamp(y + rec_q[1], 32);
          rec_q[1] = rec_q[0];
          rec_q[0] = w;
        end
        alpf_pkg::MODE_TDF2: begin
          w = clamp(x + rec_q[0], 32);
          rec_q[0] = clamp(rec_q[1] - coef_mul(w, c0_coef), 32);
          rec_q[1] = clamp(0 - coef_mul(w, c1_coef), 32);
          y = clamp(ff_q[0] + coef_mul(w, c1_coef), 32);
          ff_q[0] = clamp(ff_q[1] + coef_mul(w, c0_coef), 32);
          ff_q[1] = w;
        end
        default: y = 0;  // Undefined mode: state untouched, output zero.
      endcase
      y = clamp(y, 24);
      pending_out.push_back(y[23:0]);
    endfunction

    function void check_output(logic signed [23:0] got);
      logic signed [23:0] want;
      if (pending_out.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: sample_out expected none, actual %0d", $time, got);
        return;
      end
      want = pending_out.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: sample_out expected %0d, actual %0d", $time, want, got);
      end
    endfunction
  endclass

  bit                 clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [23:0] sample_in_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [23:0] sample_out_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;

  allpass_scoreboard filt_sb = new();
  int cycle_cnt = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  allpass_filter_section_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_out_o(sample_out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Results are checked before the item of the same edge is predicted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) filt_sb.check_output(sample_out_o);
      if (in_valid_i && !in_stall_o) filt_sb.take_sample(sample_in_i);
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [23:0] pick_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return {{16{r[7]}}, r[7:0]};
      default: return r[23:0];
    endcase
  endfunction

  // Mostly coefficients inside +-1.0 so the filter stays stable, with some
  // full-range and extreme values.
  function automatic logic [31:0] pick_coef();
    logic [31:0] u;
    case ($urandom_range(9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return $urandom();
      default: begin
        u = $urandom_range(32'h7FFFFFFE, 0);
        return u - 32'h3FFFFFFF;
      end
    endcase
  endfunction

  task automatic send_sample(input logic [23:0] x);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= x;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (filt_sb.pending_out.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic cfg_write(input alpf_pkg::reg_e idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    filt_sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // The mode value carries random upper bits, which the block must ignore.
  task automatic load_section(input logic [1:0] mode, input logic [31:0] k,
                              input logic [31:0] c0, input logic [31:0] c1);
    logic [31:0] junk;
    junk = $urandom();
    drain();
    cfg_write(alpf_pkg::REG_MODE, {junk[31:2], mode});
    cfg_write(alpf_pkg::REG_K, k);
    cfg_write(alpf_pkg::REG_C0, c0);
    cfg_write(alpf_pkg::REG_C1, c1);
  endtask

  initial begin
    logic [1:0] mode;
    int phase;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_in_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = alpf_pkg::REG_MODE;
    cfg_data_i  = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // First order at both coefficient extremes and at k = 0.5; the extremes drive it into saturation.
    load_section(alpf_pkg::MODE_FIRST, 32'h7FFFFFFF, 32'h0, 32'h0);
    send_sample(24'h7FFFFF);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h800000);
    send_sample(24'h000000);
    send_sample(24'hFFFFFF);
    load_section(alpf_pkg::MODE_FIRST, 32'h80000000, 32'h0, 32'h0);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h000001);
    load_section(alpf_pkg::MODE_FIRST, 32'h20000000, 32'h0, 32'h0);
    send_sample(24'h400000);
    send_sample(24'hC00000);
    // Second order picks up the state left by first order.
    load_section(alpf_pkg::MODE_DF2, 32'h0, 32'h80000000, 32'h7FFFFFFF);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h123456);
    load_section(alpf_pkg::MODE_DF2, 32'h0, 32'h7FFFFFFF, 32'h80000000);
    send_sample(24'h7FFFFF);
    send_sample(24'h7FFFFF);
    load_section(alpf_pkg::MODE_TDF2, 32'h0, 32'h40000000, 32'hC0000000);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h000000);
    send_sample(24'h7FFFFF);
    // The undefined mode must leave the state alone and return zero.
    load_section(2'd3, 32'h0, 32'h40000000, 32'hC0000000);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    load_section(alpf_pkg::MODE_TDF2, 32'h0, 32'h40000000, 32'hC0000000);
    send_sample(24'h000000);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      phase = seg % 4;
      idle_pct  = (phase == 1) ? 78 : (phase == 3) ? 32 : 0;
      stall_pct = (phase == 2) ? 78 : (phase == 3) ? 32 : 0;
      mode = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
      load_section(mode, pick_coef(), pick_coef(), pick_coef());
      for (int n = 0; n < SEGMENT_ITEMS; n++) send_sample(pick_sample());
    end

    drain();
    repeat (30) @(posedge clk_i);
    if (filt_sb.errors == 0 && filt_sb.pending_out.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ allpass_filter_section_unit.f @@
hdl/alpf_pkg.sv
hdl/alpf_fmul.sv
hdl/alpf_alu.sv
hdl/alpf_ctrl.sv
hdl/allpass_filter_section_unit.sv
sim/tb_top.sv
